// ----- sv/msrc_pkg.sv -----
// Types, codes and routing-table functions for the matrix switch route controller.
// No dependencies; used by the channel interfaces and by every module.
`timescale 1ns / 1ps

package msrc_pkg;

  localparam int NumPorts = 3;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  typedef logic [1:0] route_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] button_levels;
    logic [7:0] want_in1;
    logic [7:0] want_in2;
    logic [7:0] want_in3;
    logic [7:0] save;
  } item_t;

  typedef struct packed {
    logic [11:0] relay_on;
    logic [8:0]  led_on;
    route_t      route1;
    route_t      route2;
    route_t      route3;
    logic        store_request;
    logic [1:0]  held;
  } result_t;

  // routes[k] is the output chosen for input k+1
  typedef struct packed {
    route_t [NumPorts-1:0] routes;
    logic [1:0]            held_button;
    logic                  flip_pending;
    logic [1:0]            last_button;
  } sw_state_t;

  function automatic logic [1:0] next_idx(logic [1:0] k);
    next_idx = (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  // one button press; k is the button index (button number minus one)
  function automatic sw_state_t press_step(sw_state_t s, logic [1:0] k);
    sw_state_t  r;
    logic [1:0] n1;
    logic [1:0] n2;
    route_t     t;
    r  = s;
    n1 = next_idx(k);
    n2 = next_idx(n1);
    if (s.flip_pending && s.last_button == k + 2'd1) begin
      t           = r.routes[k];
      r.routes[k] = r.routes[n1];
      r.routes[n1] = t;
      r.flip_pending = 1'b0;
    end else begin
      t            = r.routes[n1];
      r.routes[n1] = r.routes[n2];
      r.routes[n2] = t;
      r.flip_pending = 1'b1;
      r.last_button  = k + 2'd1;
    end
    r.held_button = k + 2'd1;
    press_step = r;
  endfunction

  function automatic route_t clamp_want(logic [7:0] w, route_t own);
    clamp_want = (w > 8'd3) ? own : w[1:0];
  endfunction

  function automatic logic [11:0] relay_mask(logic [1:0] k, route_t r);
    logic [11:0] m;
    m = 12'h000;
    case (k)
      2'd0: begin
        if (r == 2'd2) m = 12'h111;
        else if (r == 2'd3) m = 12'h021;
      end
      2'd1: begin
        if (r == 2'd1) m = 12'h04A;
        else if (r == 2'd3) m = 12'hA00;
      end
      2'd2: begin
        if (r == 2'd1) m = 12'h00C;
        else if (r == 2'd2) m = 12'h480;
      end
      default: m = 12'h000;
    endcase
    relay_mask = m;
  endfunction

  function automatic logic [2:0] led_bits(route_t r);
    led_bits = {r == 2'd3, r == 2'd2, r == 2'd1};
  endfunction

endpackage

// ----- sv/msrc_item_if.sv -----
// Valid/ready channel carrying one input beat of the route controller.
// Depends on msrc_pkg for the payload type.
`timescale 1ns / 1ps

interface msrc_item_if;
  logic           valid;
  logic           ready;
  msrc_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/msrc_result_if.sv -----
// Valid/ready channel carrying one result beat of the route controller.
// Depends on msrc_pkg for the payload type.
`timescale 1ns / 1ps

interface msrc_result_if;
  logic             valid;
  logic             ready;
  msrc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/matrix_switch_route_controller.sv -----
// Top level of the 3x3 relay matrix route controller.
// Depends on msrc_pkg, msrc_item_if, msrc_result_if, msrc_in_reg, msrc_engine, msrc_decode.
//
//   channel   dir   payload
//   items     in    mode, button_levels, want_in1..3, save
//   results   out   relay_on, led_on, route1..3, store_request, held
//
// One beat per cycle sustained while results are taken; an accepted beat
// waits in the input register, then its result in the result register. The
// state update is one pass of logic between those registers. Reset sets
// routes to 1, 2, 3 and clears held, flip and last button. A stalled result
// holds in its register while the input register still takes one more beat.
`timescale 1ns / 1ps

module matrix_switch_route_controller (
  input  logic        clk,
  input  logic        rst,
  msrc_item_if.sink   items,
  msrc_result_if.source results
);
  import msrc_pkg::*;

  logic      full;
  logic      fire;
  item_t     item;
  sw_state_t state_next;
  logic      store;
  result_t   result_next;
  logic      out_valid;
  result_t   out_data;

  assign fire = full && (!out_valid || results.ready);

  msrc_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .take  (fire),
    .full  (full),
    .item  (item)
  );

  msrc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (item),
    .state_next (state_next),
    .store      (store)
  );

  msrc_decode u_decode (
    .state  (state_next),
    .store  (store),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result_next;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;
endmodule

// ----- sv/msrc_in_reg.sv -----
// Input register stage: captures one beat and holds it until the core takes it.
// Depends on msrc_pkg and msrc_item_if.
`timescale 1ns / 1ps

module msrc_in_reg (
  input  logic            clk,
  input  logic            rst,
  msrc_item_if.sink       items,
  input  logic            take,
  output logic            full,
  output msrc_pkg::item_t item
);
  import msrc_pkg::*;

  assign items.ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (items.ready) begin
      full <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item <= items.data;
    end
  end
endmodule

// ----- sv/msrc_engine.sv -----
// Switch state registers and the per-beat update for scan and set beats.
// Depends on msrc_pkg.
`timescale 1ns / 1ps

module msrc_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  msrc_pkg::item_t     item,
  output msrc_pkg::sw_state_t state_next,
  output logic                store
);
  import msrc_pkg::*;

  sw_state_t state;

  always_comb begin
    logic same;
    state_next = state;
    store      = 1'b0;
    same       = 1'b0;
    if (item.mode == MODE_SCAN) begin
      if (state.held_button != 2'd0) begin
        if (item.button_levels[state.held_button - 2'd1]) begin
          state_next.held_button = 2'd0;
        end
      end else begin
        for (int i = 0; i < NumPorts; i++) begin
          if (!item.button_levels[i]) begin
            state_next = press_step(state_next, 2'(i));
            store      = 1'b1;
          end
        end
      end
    end else begin
      same = {6'd0, state.routes[0]} == item.want_in1 &&
             {6'd0, state.routes[1]} == item.want_in2 &&
             {6'd0, state.routes[2]} == item.want_in3 &&
             item.save == 8'd0;
      if (!same) begin
        state_next.routes[0] = clamp_want(item.want_in1, 2'd1);
        state_next.routes[1] = clamp_want(item.want_in2, 2'd2);
        state_next.routes[2] = clamp_want(item.want_in3, 2'd3);
        store = (item.save == 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.routes       <= {2'd3, 2'd2, 2'd1};
      state.held_button  <= 2'd0;
      state.flip_pending <= 1'b0;
      state.last_button  <= 2'd0;
    end else if (fire) begin
      state <= state_next;
    end
  end
endmodule

// ----- sv/msrc_decode.sv -----
// Decodes the three routes into relay drive and route LED bits.
// Depends on msrc_pkg.
`timescale 1ns / 1ps

module msrc_decode (
  input  msrc_pkg::sw_state_t state,
  input  logic                store,
  output msrc_pkg::result_t   result
);
  import msrc_pkg::*;

  always_comb begin
    result.relay_on = relay_mask(2'd0, state.routes[0]) |
                      relay_mask(2'd1, state.routes[1]) |
                      relay_mask(2'd2, state.routes[2]);
    result.led_on   = {led_bits(state.routes[2]), led_bits(state.routes[1]),
                       led_bits(state.routes[0])};
    result.route1        = state.routes[0];
    result.route2        = state.routes[1];
    result.route3        = state.routes[2];
    result.store_request = store;
    result.held          = state.held_button;
  end
endmodule
